// ----- src/kmr_pkg.sv -----
package kmr_pkg;

  localparam int KEY_W    = 16;
  localparam int CMD_W    = 3;
  localparam int SLOT_W   = 4;
  localparam int POS_W    = 8;
  localparam int STATUS_W = 4;
  localparam int CFG_ADDR_W = 1;

  // Alt-digit decode: one digit per 256 codes, digit = (group + 1) mod 10
  localparam int ALT_STEP_SHIFT = 8;
  localparam int DIGIT_COUNT    = 10;
  localparam int DIV10_MUL      = 205;
  localparam int DIV10_SHIFT    = 11;

  localparam logic [KEY_W-1:0] ALT_FIRST_RESET = 16'h7800;
  localparam logic [KEY_W-1:0] ALT_LAST_RESET  = 16'h8100;

  typedef enum logic [CMD_W-1:0] {
    CMD_KEY   = 3'd0,
    CMD_PULL  = 3'd1,
    CMD_REC   = 3'd2,
    CMD_FLUSH = 3'd3,
    CMD_PEEK  = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 4'd0,
    ST_BUSY     = 4'd1,
    ST_REC_DONE = 4'd2,
    ST_PLAY     = 4'd3,
    ST_EMPTY    = 4'd4,
    ST_WRONG    = 4'd5,
    ST_OVERFLOW = 4'd6,
    ST_REFUSED  = 4'd7,
    ST_NOTHING  = 4'd8
  } status_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ALT_FIRST = 1'd0,
    REG_ALT_LAST  = 1'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load_item;
    logic rd_en;
    logic commit;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic needs_read;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- src/keystroke_macro_recorder.sv -----
// Channel  Direction  Handshake            Payload
// in       slave      in_tvalid/in_tready  tuser: cmd; tdata: key_code, slot
// out      master     out_tvalid/tready    tdata: key_valid, key_out, recording_on,
//                                          playing_on; tuser: status; tlast: last
// cfg      write      cfg_we               cfg_addr: register, cfg_wdata: value
//
// An item passes through decode and commit; pull and peek during playback
// add a read state for the registered read of the macro store.
// Input is taken only while the controller is idle; one result register holds
// a finished item, and commit waits while it holds one the consumer does not take.
// Reset synchronously clears modes, position and slot lengths; the store needs no clear.
module keystroke_macro_recorder
  import kmr_pkg::*;
  #(
    parameter int SLOT_COUNT  = 10,
    parameter int MACRO_DEPTH = 128
  )
  (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_tvalid,
    output logic                  in_tready,
    input  logic [23:0]           in_tdata,   // [15:0] key_code, [19:16] slot, zero pad
    input  logic [CMD_W-1:0]      in_tuser,   // [2:0] cmd
    output logic                  out_tvalid,
    input  logic                  out_tready,
    output logic [23:0]           out_tdata,  // [0] key_valid, [16:1] key_out,
                                              // [17] recording_on, [18] playing_on, pad
    output logic [STATUS_W-1:0]   out_tuser,  // [3:0] status
    output logic                  out_tlast,  // last_of_macro
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [KEY_W-1:0]      cfg_wdata
  );

  ctrl_cmd_t        ctrl;
  dp_stat_t         stat;
  logic             key_valid;
  logic [KEY_W-1:0] key_out;
  logic             rec_on;
  logic             play_on;

  kmr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (ctrl)
  );

  kmr_dp #(
    .SLOT_COUNT  (SLOT_COUNT),
    .MACRO_DEPTH (MACRO_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (ctrl),
    .stat              (stat),
    .in_cmd            (in_tuser),
    .in_key_code       (in_tdata[15:0]),
    .in_slot           (in_tdata[19:16]),
    .cfg_we            (cfg_we),
    .cfg_addr          (cfg_addr),
    .cfg_wdata         (cfg_wdata),
    .out_tvalid        (out_tvalid),
    .out_tready        (out_tready),
    .out_key_valid     (key_valid),
    .out_key_out       (key_out),
    .out_last_of_macro (out_tlast),
    .out_status        (out_tuser),
    .out_recording_on  (rec_on),
    .out_playing_on    (play_on)
  );

  assign out_tdata = {5'd0, play_on, rec_on, key_out, key_valid};

endmodule

// ----- src/kmr_ram.sv -----
module kmr_ram
  #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1280,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
  )
  (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_W-1:0]    waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic                 re,
    input  logic [ADDR_W-1:0]    raddr,
    output logic [WIDTH-1:0]     rdata
  );

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/kmr_ctrl.sv -----
module kmr_ctrl
  import kmr_pkg::*;
  (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_tvalid,
    output logic      in_tready,
    input  dp_stat_t  stat,
    output ctrl_cmd_t cmd
  );

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_tready     = 1'b0;
    cmd.load_item = 1'b0;
    cmd.rd_en     = 1'b0;
    cmd.commit    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        // refuse items while reset is held
        in_tready = rst_n;
        if (rst_n && in_tvalid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.needs_read) begin
          // fetch the playback key, finish in S_READ
          cmd.rd_en = 1'b1;
          state_nxt = S_READ;
        end else if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_READ: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- src/kmr_dp.sv -----
module kmr_dp
  import kmr_pkg::*;
  #(
    parameter int SLOT_COUNT  = 10,
    parameter int MACRO_DEPTH = 128
  )
  (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ctrl_cmd_t             cmd,
    output dp_stat_t              stat,
    input  logic [CMD_W-1:0]      in_cmd,
    input  logic [KEY_W-1:0]      in_key_code,
    input  logic [SLOT_W-1:0]     in_slot,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [KEY_W-1:0]      cfg_wdata,
    output logic                  out_tvalid,
    input  logic                  out_tready,
    output logic                  out_key_valid,
    output logic [KEY_W-1:0]      out_key_out,
    output logic                  out_last_of_macro,
    output logic [STATUS_W-1:0]   out_status,
    output logic                  out_recording_on,
    output logic                  out_playing_on
  );

  localparam int STORE_DEPTH = SLOT_COUNT * MACRO_DEPTH;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int FULL_ADDR_W = 12;
  localparam logic [POS_W-1:0] DEPTH_POS = POS_W'(MACRO_DEPTH);

  // configuration
  logic [KEY_W-1:0] alt_first_r, alt_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alt_first_r <= ALT_FIRST_RESET;
      alt_last_r  <= ALT_LAST_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_ALT_FIRST: alt_first_r <= cfg_wdata;
        REG_ALT_LAST:  alt_last_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // latched item
  logic [CMD_W-1:0]  cmd_r;
  logic [KEY_W-1:0]  key_r;
  logic [SLOT_W-1:0] slot_r;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      cmd_r  <= in_cmd;
      key_r  <= in_key_code;
      slot_r <= in_slot;
    end
  end

  // macro state
  logic              recording_r, recording_nxt;
  logic              playing_r, playing_nxt;
  logic [SLOT_W-1:0] cur_slot_r, cur_slot_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [POS_W-1:0]  len_r [SLOT_COUNT];

  logic              len_we;
  logic [SLOT_W-1:0] len_widx;
  logic [POS_W-1:0]  len_wdata;

  // Alt-digit decode
  logic [KEY_W-1:0]  alt_diff;
  logic [8:0]        alt_grp;
  logic [15:0]       div_prod;
  logic [4:0]        div_q;
  logic [8:0]        alt_rem;
  logic [SLOT_W-1:0] alt_digit;
  logic              alt_hit;
  logic              digit_ok;

  always_comb begin
    alt_diff  = key_r - alt_first_r;
    alt_grp   = {1'b0, alt_diff[KEY_W-1:ALT_STEP_SHIFT]} + 9'd1;
    div_prod  = 16'(alt_grp) * 16'(DIV10_MUL);
    div_q     = div_prod[DIV10_SHIFT +: 5];
    alt_rem   = alt_grp - 9'(div_q) * 9'(DIGIT_COUNT);
    alt_digit = alt_rem[SLOT_W-1:0];
    alt_hit   = (key_r >= alt_first_r) && (key_r <= alt_last_r);
    digit_ok  = 32'(alt_digit) < SLOT_COUNT;
  end

  // length lookup, one read index
  logic [SLOT_W-1:0] len_ridx;
  logic [POS_W-1:0]  len_sel;

  always_comb begin
    len_ridx = (cmd_t'(cmd_r) == CMD_KEY) ? alt_digit : cur_slot_r;
    len_sel  = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (len_ridx == SLOT_W'(i)) begin
        len_sel = len_r[i];
      end
    end
  end

  // macro store
  logic [FULL_ADDR_W-1:0] addr_full;
  logic [ADDR_W-1:0]      store_addr;
  logic                   store_we;
  logic [KEY_W-1:0]       store_rdata;
  logic [POS_W-1:0]       pos_inc;

  assign addr_full  = FULL_ADDR_W'(cur_slot_r) * FULL_ADDR_W'(MACRO_DEPTH)
                    + FULL_ADDR_W'(pos_r);
  assign store_addr = addr_full[ADDR_W-1:0];
  assign pos_inc    = pos_r + POS_W'(1);

  kmr_ram #(
    .WIDTH (KEY_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (store_addr),
    .wdata (key_r),
    .re    (cmd.rd_en),
    .raddr (store_addr),
    .rdata (store_rdata)
  );

  // result and next state
  logic                res_valid;
  logic [KEY_W-1:0]    res_key;
  logic                res_last;
  logic [STATUS_W-1:0] res_status;
  logic                wr_key;

  always_comb begin
    recording_nxt = recording_r;
    playing_nxt   = playing_r;
    cur_slot_nxt  = cur_slot_r;
    pos_nxt       = pos_r;
    len_we        = 1'b0;
    len_widx      = cur_slot_r;
    len_wdata     = '0;
    res_valid     = 1'b0;
    res_key       = '0;
    res_last      = 1'b0;
    res_status    = ST_NOTHING;
    wr_key        = 1'b0;
    unique case (cmd_r)
      CMD_KEY: begin
        if (playing_r) begin
          res_status = ST_BUSY;
        end else if (alt_hit) begin
          if (recording_r) begin
            if (digit_ok && alt_digit == cur_slot_r) begin
              recording_nxt = 1'b0;
              len_we        = 1'b1;
              len_widx      = alt_digit;
              len_wdata     = pos_r;
              res_status    = ST_REC_DONE;
            end else begin
              res_status = ST_WRONG;
            end
          end else if (digit_ok && len_sel != '0) begin
            playing_nxt  = 1'b1;
            cur_slot_nxt = alt_digit;
            pos_nxt      = '0;
            res_status   = ST_PLAY;
          end else begin
            res_status = ST_EMPTY;
          end
        end else begin
          res_valid  = 1'b1;
          res_key    = key_r;
          res_status = ST_OK;
          if (recording_r) begin
            if (pos_r >= DEPTH_POS) begin
              recording_nxt = 1'b0;
              len_we        = 1'b1;
              len_wdata     = DEPTH_POS;
              res_status    = ST_OVERFLOW;
            end else begin
              wr_key  = 1'b1;
              pos_nxt = pos_inc;
            end
          end
        end
      end
      CMD_PULL: begin
        if (playing_r) begin
          res_valid  = 1'b1;
          res_key    = store_rdata;
          pos_nxt    = pos_inc;
          res_status = ST_OK;
          if (pos_inc >= len_sel) begin
            playing_nxt = 1'b0;
            res_last    = 1'b1;
          end
        end
      end
      CMD_REC: begin
        if (recording_r || playing_r || 32'(slot_r) >= SLOT_COUNT) begin
          res_status = ST_REFUSED;
        end else begin
          recording_nxt = 1'b1;
          pos_nxt       = '0;
          len_we        = 1'b1;
          len_widx      = slot_r;
          len_wdata     = '0;
          cur_slot_nxt  = slot_r;
          res_status    = ST_OK;
        end
      end
      CMD_FLUSH: begin
        playing_nxt = 1'b0;
        res_status  = ST_OK;
      end
      CMD_PEEK: begin
        if (playing_r) begin
          res_valid  = 1'b1;
          res_key    = store_rdata;
          res_status = ST_OK;
        end
      end
      default: ;
    endcase
  end

  assign store_we        = cmd.commit && wr_key;
  assign stat.needs_read = playing_r
                        && (cmd_t'(cmd_r) == CMD_PULL || cmd_t'(cmd_r) == CMD_PEEK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recording_r <= 1'b0;
      playing_r   <= 1'b0;
      cur_slot_r  <= '0;
      pos_r       <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        len_r[i] <= '0;
      end
    end else if (cmd.commit) begin
      recording_r <= recording_nxt;
      playing_r   <= playing_nxt;
      cur_slot_r  <= cur_slot_nxt;
      pos_r       <= pos_nxt;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (len_we && len_widx == SLOT_W'(i)) begin
          len_r[i] <= len_wdata;
        end
      end
    end
  end

  // output register
  logic out_valid_r;

  assign stat.out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_key_valid     <= res_valid;
      out_key_out       <= res_key;
      out_last_of_macro <= res_last;
      out_status        <= res_status;
      out_recording_on  <= recording_nxt;
      out_playing_on    <= playing_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

// ----- tb/tb_keystroke_macro_recorder.sv -----
`timescale 1ns / 1ps

module tb_keystroke_macro_recorder;
  import kmr_pkg::*;

  localparam int SLOTS        = 10;
  localparam int DEPTH        = 128;
  localparam int PHASE_QUOTA  = 40;
  localparam int PHASE_COUNT  = 7;
  localparam int DRAIN_CYCLES = 10;
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  typedef struct packed {
    logic             kv;
    logic [KEY_W-1:0] key;
    logic             last;
    status_t          st;
    logic             rec;
    logic             play;
  } macro_resp_t;

  typedef struct {
    logic [CMD_W-1:0]  c;
    logic [KEY_W-1:0]  k;
    logic [SLOT_W-1:0] s;
    bit                typed;
    macro_resp_t       want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [23:0] in_tdata;
  logic [CMD_W-1:0] in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [23:0] out_tdata;
  logic [STATUS_W-1:0] out_tuser;
  logic out_tlast;
  logic cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [KEY_W-1:0] cfg_wdata;

  // mirror of the recorder state
  logic [KEY_W-1:0]  alt_lo;
  logic [KEY_W-1:0]  alt_hi;
  logic              rec_on;
  logic              play_on;
  logic [SLOT_W-1:0] cur_slot;
  logic [POS_W-1:0]  cur_pos;
  logic [POS_W-1:0]  slot_len [SLOTS];
  logic [KEY_W-1:0]  key_mem [SLOTS*DEPTH];

  macro_resp_t pending_resp [$];
  stim_row_t   script [$];
  int fed_items = 0;
  int result_idx = 0;
  int fail_count = 0;
  int tx_burst = 0;
  int rx_burst = 0;

  keystroke_macro_recorder DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin : watchdog
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic macro_resp_t predict_macro_item(input logic [CMD_W-1:0] c,
                                                     input logic [KEY_W-1:0] k,
                                                     input logic [SLOT_W-1:0] s);
    macro_resp_t r;
    int unsigned digit;
    r = '{kv: 1'b0, key: '0, last: 1'b0, st: ST_NOTHING, rec: 1'b0, play: 1'b0};
    case (c)
      CMD_KEY: begin
        if (play_on) begin
          r.st = ST_BUSY;
        end else if (k >= alt_lo && k <= alt_hi) begin
          digit = (((32'(k) - 32'(alt_lo)) >> 8) + 1) % 10;
          if (rec_on) begin
            if (digit < SLOTS && digit == cur_slot) begin
              rec_on = 1'b0;
              slot_len[digit] = cur_pos;
              r.st = ST_REC_DONE;
            end else begin
              r.st = ST_WRONG;
            end
          end else if (digit < SLOTS && slot_len[digit] != 0) begin
            play_on = 1'b1;
            cur_slot = SLOT_W'(digit);
            cur_pos = '0;
            r.st = ST_PLAY;
          end else begin
            r.st = ST_EMPTY;
          end
        end else begin
          r.kv = 1'b1;
          r.key = k;
          r.st = ST_OK;
          if (rec_on) begin
            if (cur_pos >= DEPTH) begin
              // store full: key still goes out, recording stops at full length
              rec_on = 1'b0;
              slot_len[cur_slot] = POS_W'(DEPTH);
              r.st = ST_OVERFLOW;
            end else begin
              key_mem[int'(cur_slot) * DEPTH + int'(cur_pos)] = k;
              cur_pos = cur_pos + 1'b1;
            end
          end
        end
      end
      CMD_PULL: begin
        if (play_on) begin
          r.kv = 1'b1;
          r.key = key_mem[int'(cur_slot) * DEPTH + int'(cur_pos)];
          cur_pos = cur_pos + 1'b1;
          if (cur_pos >= slot_len[cur_slot]) begin
            play_on = 1'b0;
            r.last = 1'b1;
          end
          r.st = ST_OK;
        end
      end
      CMD_REC: begin
        if (rec_on || play_on || s >= SLOTS) begin
          r.st = ST_REFUSED;
        end else begin
          rec_on = 1'b1;
          cur_pos = '0;
          slot_len[s] = '0;
          cur_slot = s;
          r.st = ST_OK;
        end
      end
      CMD_FLUSH: begin
        play_on = 1'b0;
        r.st = ST_OK;
      end
      CMD_PEEK: begin
        if (play_on) begin
          r.kv = 1'b1;
          r.key = key_mem[int'(cur_slot) * DEPTH + int'(cur_pos)];
          r.st = ST_OK;
        end
      end
      default: begin
      end
    endcase
    r.rec = rec_on;
    r.play = play_on;
    return r;
  endfunction

  function automatic string resp_str(input macro_resp_t r);
    return $sformatf("valid %0b key %04h last %0b status %0d rec %0b play %0b",
                     r.kv, r.key, r.last, r.st, r.rec, r.play);
  endfunction

  function automatic int draw_idle(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      burst = $urandom_range(8, 24);
      return 0;
    end
    return $urandom_range(0, 10);
  endfunction

  // key that decodes to digit d under the current Alt range, when the range allows
  function automatic logic [KEY_W-1:0] alt_key(input int d);
    int code;
    code = int'(alt_lo) + ((d + 9) % 10) * 256 + $urandom_range(0, 255);
    if ($urandom_range(0, 3) == 0 && code + 2560 <= int'(alt_hi))
      code += 2560;
    if (alt_lo > alt_hi)
      return KEY_W'($urandom);
    if (code > int'(alt_hi))
      code = int'(alt_hi);
    return KEY_W'(code);
  endfunction

  function automatic logic [KEY_W-1:0] raw_key();
    logic [KEY_W-1:0] k;
    k = KEY_W'($urandom);
    for (int i = 0; i < 16; i++) begin
      if (k < alt_lo || k > alt_hi)
        return k;
      k = KEY_W'($urandom);
    end
    return k;
  endfunction

  task automatic push_row(input logic [CMD_W-1:0] c, input logic [KEY_W-1:0] k,
                          input logic [SLOT_W-1:0] s, input bit typed = 1'b0,
                          input status_t st = ST_NOTHING, input logic kv = 1'b0,
                          input logic [KEY_W-1:0] ko = '0, input logic rec = 1'b0,
                          input logic play = 1'b0);
    stim_row_t row;
    row.c = c;
    row.k = k;
    row.s = s;
    row.typed = typed;
    row.want = '{kv: kv, key: ko, last: 1'b0, st: st, rec: rec, play: play};
    script.push_back(row);
  endtask

  // called at a rising edge; returns at the edge that accepts the item
  task automatic send_item(input logic [CMD_W-1:0] c, input logic [KEY_W-1:0] k,
                           input logic [SLOT_W-1:0] s, input bit typed = 1'b0,
                           input macro_resp_t want = '0);
    int gap;
    macro_resp_t r;
    gap = draw_idle(tx_burst);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= c;
    in_tdata <= {4'h0, s, k};
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    r = predict_macro_item(c, k, s);
    pending_resp.push_back(typed ? want : r);
    if (c <= CMD_PEEK)
      fed_items++;
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_resp.size() != 0);
  endtask

  task automatic load_alt_range(input logic [KEY_W-1:0] lo, input logic [KEY_W-1:0] hi);
    wait_drain();
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= REG_ALT_FIRST;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_addr <= REG_ALT_LAST;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_we <= 1'b0;
    alt_lo = lo;
    alt_hi = hi;
  endtask

  task automatic record_macro(input bit overflow);
    int n;
    int d;
    if (play_on)
      send_item(CMD_FLUSH, KEY_W'($urandom), SLOT_W'($urandom));
    if (rec_on)
      send_item(CMD_KEY, alt_key(cur_slot), SLOT_W'($urandom));
    d = $urandom_range(0, SLOTS - 1);
    send_item(CMD_REC, KEY_W'($urandom), SLOT_W'(d));
    n = overflow ? DEPTH + 1 : $urandom_range(0, 12);
    for (int i = 0; i < n; i++) begin
      if (!overflow && $urandom_range(0, 9) == 0)
        send_item(CMD_KEY, alt_key((d + $urandom_range(1, 9)) % 10), SLOT_W'($urandom));
      else if (!overflow && $urandom_range(0, 19) == 0)
        send_item($urandom_range(0, 1) ? CMD_PULL : CMD_PEEK, KEY_W'($urandom),
                  SLOT_W'($urandom));
      else
        send_item(CMD_KEY, raw_key(), SLOT_W'($urandom));
    end
    // leave recording open now and then
    if (overflow || $urandom_range(0, 6) != 0)
      send_item(CMD_KEY, alt_key(d), SLOT_W'($urandom));
  endtask

  task automatic play_macro();
    int filled [$];
    int d;
    int guard;
    if (rec_on)
      send_item(CMD_KEY, alt_key(cur_slot), SLOT_W'($urandom));
    if (!play_on) begin
      for (int i = 0; i < SLOTS; i++)
        if (slot_len[i] != 0)
          filled.push_back(i);
      if (filled.size() != 0)
        d = filled[$urandom_range(0, filled.size() - 1)];
      else
        d = $urandom_range(0, SLOTS - 1);
      send_item(CMD_KEY, alt_key(d), SLOT_W'($urandom));
    end
    guard = 0;
    while (play_on && guard < 400) begin
      guard++;
      case ($urandom_range(0, 19))
        0, 1, 2: send_item(CMD_PEEK, KEY_W'($urandom), SLOT_W'($urandom));
        3:       send_item(CMD_KEY, raw_key(), SLOT_W'($urandom));
        4:       send_item(CMD_REC, KEY_W'($urandom), SLOT_W'($urandom_range(0, 9)));
        5: begin
          if ($urandom_range(0, 3) == 0)
            send_item(CMD_FLUSH, KEY_W'($urandom), SLOT_W'($urandom));
          else
            send_item(CMD_PULL, KEY_W'($urandom), SLOT_W'($urandom));
        end
        default: send_item(CMD_PULL, KEY_W'($urandom), SLOT_W'($urandom));
      endcase
    end
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 4);
    repeat (n)
      send_item(CMD_W'($urandom_range(0, 7)), KEY_W'($urandom), SLOT_W'($urandom));
  endtask

  always @(posedge clk) begin
    macro_resp_t got;
    macro_resp_t want;
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      got.kv = out_tdata[0];
      got.key = out_tdata[16:1];
      got.last = out_tlast;
      got.st = status_t'(out_tuser);
      got.rec = out_tdata[17];
      got.play = out_tdata[18];
      if (pending_resp.size() == 0) begin
        if (fail_count < 10)
          $display("result %0d arrived with nothing pending: %s", result_idx, resp_str(got));
        fail_count++;
      end else begin
        want = pending_resp.pop_front();
        if (got !== want) begin
          if (fail_count < 10)
            $display("result %0d mismatch\n  want %s\n  got  %s",
                     result_idx, resp_str(want), resp_str(got));
          fail_count++;
        end
      end
      result_idx++;
    end
  end

  initial begin : consumer
    int stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = draw_idle(rx_burst);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (out_tvalid !== 1'b1) @(posedge clk);
    end
  end

  initial begin : producer
    logic [KEY_W-1:0] lo_set [PHASE_COUNT];
    logic [KEY_W-1:0] hi_set [PHASE_COUNT];
    int start;
    int pick;
    bit paused;

    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = CMD_KEY;
    cfg_we = 1'b0;
    cfg_addr = REG_ALT_FIRST;
    cfg_wdata = '0;
    alt_lo = ALT_FIRST_RESET;
    alt_hi = ALT_LAST_RESET;
    rec_on = 1'b0;
    play_on = 1'b0;
    cur_slot = '0;
    cur_pos = '0;
    foreach (slot_len[i]) slot_len[i] = '0;
    paused = 1'b0;

    // reset Alt range: Alt-1 = 7800, Alt-2 = 7900, ..., Alt-0 = 8100
    push_row(CMD_PULL, 16'h0000, 4'd0, 1'b1, ST_NOTHING);
    push_row(CMD_PEEK, 16'hFFFF, 4'd15, 1'b1, ST_NOTHING);
    push_row(CMD_FLUSH, 16'h0000, 4'd0, 1'b1, ST_OK);
    push_row(CMD_SPARE_LO, 16'h0000, 4'd0, 1'b1, ST_NOTHING);
    push_row(CMD_SPARE_HI, 16'hFFFF, 4'd15, 1'b1, ST_NOTHING);
    push_row(CMD_KEY, 16'h0000, 4'd0, 1'b1, ST_OK, 1'b1, 16'h0000);
    push_row(CMD_KEY, 16'hFFFF, 4'd15, 1'b1, ST_OK, 1'b1, 16'hFFFF);
    push_row(CMD_KEY, 16'h7800, 4'd0, 1'b1, ST_EMPTY);
    push_row(CMD_KEY, 16'h8100, 4'd0, 1'b1, ST_EMPTY);
    push_row(CMD_REC, 16'h0000, 4'd10, 1'b1, ST_REFUSED);
    push_row(CMD_REC, 16'h0000, 4'd15, 1'b1, ST_REFUSED);
    push_row(CMD_REC, 16'h0000, 4'd0, 1'b1, ST_OK, 1'b0, 16'h0000, 1'b1);
    push_row(CMD_REC, 16'h0000, 4'd3, 1'b1, ST_REFUSED, 1'b0, 16'h0000, 1'b1);
    push_row(CMD_KEY, 16'h1234, 4'd0, 1'b1, ST_OK, 1'b1, 16'h1234, 1'b1);
    push_row(CMD_KEY, 16'hABCD, 4'd0);
    push_row(CMD_KEY, 16'h7955, 4'd0, 1'b1, ST_WRONG, 1'b0, 16'h0000, 1'b1);
    push_row(CMD_KEY, 16'h8101, 4'd0);
    push_row(CMD_KEY, 16'h8100, 4'd0, 1'b1, ST_REC_DONE);
    push_row(CMD_KEY, 16'h81FF, 4'd0);
    push_row(CMD_KEY, 16'h8100, 4'd0, 1'b1, ST_PLAY, 1'b0, 16'h0000, 1'b0, 1'b1);
    push_row(CMD_KEY, 16'h0041, 4'd0, 1'b1, ST_BUSY, 1'b0, 16'h0000, 1'b0, 1'b1);
    push_row(CMD_REC, 16'h0000, 4'd1, 1'b1, ST_REFUSED, 1'b0, 16'h0000, 1'b0, 1'b1);
    push_row(CMD_PEEK, 16'h0000, 4'd0);
    push_row(CMD_PULL, 16'h0000, 4'd0);
    push_row(CMD_PULL, 16'h0000, 4'd0);
    push_row(CMD_FLUSH, 16'h0000, 4'd0, 1'b1, ST_OK);
    push_row(CMD_PULL, 16'h0000, 4'd0, 1'b1, ST_NOTHING);
    push_row(CMD_KEY, 16'h7FFF, 4'd0, 1'b1, ST_EMPTY);

    lo_set[0] = ALT_FIRST_RESET; hi_set[0] = ALT_LAST_RESET;
    lo_set[1] = 16'h0000;        hi_set[1] = 16'h09FF;
    lo_set[2] = 16'hF600;        hi_set[2] = 16'hFFFF;
    lo_set[3] = 16'hFFFF;        hi_set[3] = 16'h0000;   // empty range
    lo_set[4] = 16'h0000;        hi_set[4] = 16'hFFFF;   // every key is an Alt digit
    lo_set[5] = 16'hFFFF;        hi_set[5] = 16'hFFFF;
    lo_set[6] = KEY_W'($urandom_range(0, 16'hC000));
    hi_set[6] = lo_set[6] + KEY_W'($urandom_range(0, 16'h3FFF));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i])
      send_item(script[i].c, script[i].k, script[i].s, script[i].typed, script[i].want);

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      load_alt_range(lo_set[phase], hi_set[phase]);
      start = fed_items;
      if (phase == 0)
        record_macro(1'b1);
      while (fed_items - start < PHASE_QUOTA) begin
        pick = $urandom_range(0, 99);
        if (pick < 40)
          record_macro(1'b0);
        else if (pick < 75)
          play_macro();
        else
          send_noise();
        // hold the sender until the pipeline is empty once mid-phase
        if (phase == 2 && !paused && fed_items - start > 30) begin
          wait_drain();
          paused = 1'b1;
        end
      end
    end

    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_resp.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/kmr_pkg.sv
src/kmr_ram.sv
src/kmr_ctrl.sv
src/kmr_dp.sv
src/keystroke_macro_recorder.sv
tb/tb_keystroke_macro_recorder.sv
